>>> rtl/core/pul_pkg.sv
// ----------------------------------------------------------------------------
// pul_pkg
// Shared types and constants of the positivity update limiter.
// ----------------------------------------------------------------------------
package pul_pkg;

    localparam int FRAC_BITS = 16;
    localparam int BIS_STEPS = 16;
    localparam int STEP_W    = $clog2(BIS_STEPS + 1);

    localparam logic [16:0] ONE_FX = 17'(1 << FRAC_BITS);

    localparam logic [1:0] ST_UNCHANGED = 2'd0;
    localparam logic [1:0] ST_SCALED    = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;

    localparam logic REG_HEAT_RATIO = 1'b0;
    localparam logic REG_FLOOR_FRAC = 1'b1;

    localparam logic [17:0] HEAT_RATIO_RST = 18'd91750;
    localparam logic [15:0] FLOOR_FRAC_RST = 16'd6554;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CAND_STATE,
        CMD_CAND_TEST,
        CMD_SQUARE,
        CMD_DIV_KIN,
        CMD_INNER,
        CMD_PMUL,
        CMD_SET_P0,
        CMD_CAP_PREP,
        CMD_DIV_CAP,
        CMD_CAP_SET,
        CMD_TEST_ALPHA,
        CMD_BIS_INIT,
        CMD_TEST_MID,
        CMD_BIS_UPDATE,
        CMD_BIS_DONE,
        CMD_FINAL
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAND,
        S_SQ,
        S_DIVK,
        S_WAITK,
        S_INNER,
        S_PMUL,
        S_EVAL,
        S_CAP_PREP,
        S_CAP_DEC,
        S_CAP_WAIT,
        S_CHECK,
        S_BIS_INIT,
        S_BIS_MID,
        S_BIS_DONE,
        S_FINAL
    } state_t;

    typedef enum logic [1:0] {
        PH_P0,
        PH_FIRST,
        PH_BIS
    } phase_t;

    typedef struct packed {
        cmd_t cmd;
    } ctrl_t;

    typedef struct packed {
        logic div_busy;
        logic p_valid;
        logic p_pass;
        logic cap_need;
        logic alpha_pos;
        logic invalid;
    } stat_t;

    typedef struct packed {
        logic [31:0] delta_energy;
        logic [31:0] delta_momentum_y;
        logic [31:0] delta_momentum_x;
        logic [31:0] delta_density;
        logic [16:0] scale_factor;
        logic [1:0]  limit_status;
        logic        last_cell;
    } result_t;

endpackage

>>> rtl/core/positivity_update_limiter.sv
// ----------------------------------------------------------------------------
// positivity_update_limiter
// Scales a proposed Euler update so density and pressure stay positive.
// ----------------------------------------------------------------------------
// One cell is worked on at a time. Every pressure check runs through a shared
// one-bit-per-cycle 64-bit divider. A cell with an invalid state ends after
// its first pressure check, a cell that needs no bisection may add the density
// cap division, and a cell that is bisected runs BIS_STEPS more checks, 16 in
// this package. The last step waits while the output register still holds an
// unaccepted word. A new word is taken while a finished result still waits on
// the output register.
module positivity_update_limiter (
    input  logic         aclk,
    input  logic         aresetn,
    // density, momentum_x, momentum_y, total_energy, delta_density,
    // delta_momentum_x, delta_momentum_y, delta_energy
    input  logic [255:0] s_tdata,
    input  logic         s_tlast,
    input  logic         s_tvalid,
    output logic         s_tready,
    // scaled_delta_density, scaled_delta_momentum_x, scaled_delta_momentum_y,
    // scaled_delta_energy, scale_factor, zero padding
    output logic [151:0] m_tdata,
    // limit_status
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [17:0]  cfg_wdata
);
    import pul_pkg::*;

    logic [17:0] heat_ratio_reg;
    logic [15:0] floor_frac_reg;
    result_t     out_reg;
    logic        m_valid_reg;
    logic        out_load;
    logic        out_free;
    ctrl_t       ctrl;
    stat_t       stat;
    result_t     result;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heat_ratio_reg <= HEAT_RATIO_RST;
            floor_frac_reg <= FLOOR_FRAC_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_HEAT_RATIO: heat_ratio_reg <= cfg_wdata;
                REG_FLOOR_FRAC: floor_frac_reg <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= result;
        end
    end

    pul_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    pul_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .stat           (stat),
        .in_data        (s_tdata),
        .in_last        (s_tlast),
        .heat_ratio     (heat_ratio_reg),
        .floor_fraction (floor_frac_reg),
        .result         (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_reg.last_cell;
    assign m_tuser  = out_reg.limit_status;
    assign m_tdata  = {7'd0, out_reg.scale_factor, out_reg.delta_energy,
                       out_reg.delta_momentum_y, out_reg.delta_momentum_x,
                       out_reg.delta_density};
endmodule

>>> rtl/core/pul_divider.sv
// ----------------------------------------------------------------------------
// pul_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pul_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);
    logic [63:0] quo_reg;
    logic [32:0] rem_reg;
    logic [32:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [33:0] trial;
    logic [33:0] diff;

    always_comb begin
        trial = {rem_reg, quo_reg[63]};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[33]) begin
                rem_reg <= diff[32:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= trial[32:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

>>> rtl/core/pul_datapath.sv
// ----------------------------------------------------------------------------
// pul_datapath
// Registers, arithmetic and divider of the limiter, driven by commands.
// ----------------------------------------------------------------------------
module pul_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  pul_pkg::ctrl_t   ctrl,
    output pul_pkg::stat_t   stat,
    input  logic [255:0]     in_data,
    input  logic             in_last,
    input  logic [17:0]      heat_ratio,
    input  logic [15:0]      floor_fraction,
    output pul_pkg::result_t result
);
    import pul_pkg::*;

    logic signed [31:0] u_reg [4];
    logic signed [31:0] d_reg [4];
    logic signed [31:0] c_reg [4];
    logic               last_reg;
    logic               invalid_reg;
    logic [16:0]        alpha_reg;
    logic [16:0]        a_reg;
    logic [16:0]        lo_reg;
    logic [16:0]        hi_reg;
    logic [63:0]        sqx_reg;
    logic [63:0]        sqy_reg;
    logic signed [45:0] inner_reg;
    logic signed [47:0] p_reg;
    logic signed [47:0] thr_reg;
    logic               cap_need_reg;
    logic [48:0]        num_reg;

    logic signed [31:0] cand [4];
    logic signed [31:0] scaled [4];
    logic [31:0]        abs_x;
    logic [31:0]        abs_y;
    logic signed [18:0] gm1;
    logic signed [65:0] ediff;
    logic signed [64:0] pfull;
    logic signed [50:0] tfull;
    logic signed [48:0] ffu;
    logic signed [32:0] lhs;
    logic signed [32:0] rhs;
    logic signed [49:0] nfull;
    logic [16:0]        omf;
    logic [17:0]        mid_sum;
    logic               div_start;
    logic [63:0]        div_dividend;
    logic [32:0]        div_divisor;
    logic               div_busy;
    logic [63:0]        quo;

    for (genvar k = 0; k < 4; k++) begin : g_lane
        logic signed [49:0] prod;
        logic signed [49:0] sh;
        logic signed [50:0] sum;
        logic signed [49:0] fprod;

        always_comb begin
            prod  = $signed({1'b0, a_reg}) * d_reg[k];
            sh    = prod >>> FRAC_BITS;
            sum   = 51'(u_reg[k]) + 51'(sh);
            if (sum > 51'sd2147483647) begin
                cand[k] = 32'sh7FFFFFFF;
            end else if (sum < -51'sd2147483648) begin
                cand[k] = 32'sh80000000;
            end else begin
                cand[k] = sum[31:0];
            end
            fprod     = $signed({1'b0, alpha_reg}) * d_reg[k];
            scaled[k] = 32'(fprod >>> FRAC_BITS);
        end
    end

    always_comb begin
        abs_x   = c_reg[1][31] ? 32'(-c_reg[1]) : 32'(c_reg[1]);
        abs_y   = c_reg[2][31] ? 32'(-c_reg[2]) : 32'(c_reg[2]);
        gm1     = $signed({1'b0, heat_ratio}) - $signed(19'(ONE_FX));
        ediff   = 66'(c_reg[3]) - $signed({2'b00, quo});
        pfull   = gm1 * inner_reg;
        tfull   = $signed({1'b0, floor_fraction}) * $signed(p_reg[33:0]);
        ffu     = $signed({1'b0, floor_fraction}) * u_reg[0];
        lhs     = 33'(u_reg[0]) + 33'(d_reg[0]);
        rhs     = 33'(ffu >>> FRAC_BITS);
        omf     = ONE_FX - {1'b0, floor_fraction};
        nfull   = $signed({1'b0, omf}) * u_reg[0];
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};

        div_start    = (ctrl.cmd == CMD_DIV_KIN) || (ctrl.cmd == CMD_DIV_CAP);
        div_dividend = {15'd0, num_reg};
        div_divisor  = 33'(-33'(d_reg[0]));
        if (ctrl.cmd == CMD_DIV_KIN) begin
            div_dividend = sqx_reg + sqy_reg;
            div_divisor  = {c_reg[0], 1'b0};
        end
    end

    pul_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quo)
    );

    always_ff @(posedge aclk) begin
        case (ctrl.cmd)
            CMD_LOAD: begin
                for (int k = 0; k < 4; k++) begin
                    u_reg[k] <= in_data[32*k +: 32];
                    d_reg[k] <= in_data[128 + 32*k +: 32];
                end
                last_reg    <= in_last;
                alpha_reg   <= ONE_FX;
                invalid_reg <= 1'b0;
            end
            CMD_CAND_STATE: begin
                for (int k = 0; k < 4; k++) begin
                    c_reg[k] <= u_reg[k];
                end
            end
            CMD_CAND_TEST: begin
                for (int k = 0; k < 4; k++) begin
                    c_reg[k] <= cand[k];
                end
            end
            CMD_SQUARE: begin
                sqx_reg <= abs_x * abs_x;
                sqy_reg <= abs_y * abs_y;
            end
            CMD_INNER: begin
                if (ediff < -66'sd17592186044416) begin
                    inner_reg <= -46'sd17592186044416;
                end else begin
                    inner_reg <= ediff[45:0];
                end
            end
            CMD_PMUL: begin
                p_reg <= 48'(pfull >>> FRAC_BITS);
            end
            CMD_SET_P0: begin
                thr_reg     <= 48'(tfull >>> FRAC_BITS);
                invalid_reg <= !stat.p_valid;
            end
            CMD_CAP_PREP: begin
                cap_need_reg <= d_reg[0][31] && (lhs < rhs);
                num_reg      <= nfull[48:0];
            end
            CMD_CAP_SET: begin
                alpha_reg <= (quo >= 64'(ONE_FX)) ? ONE_FX : quo[16:0];
            end
            CMD_TEST_ALPHA: begin
                a_reg <= alpha_reg;
            end
            CMD_BIS_INIT: begin
                lo_reg <= '0;
                hi_reg <= alpha_reg;
            end
            CMD_TEST_MID: begin
                a_reg <= mid_sum[17:1];
            end
            CMD_BIS_UPDATE: begin
                if (stat.p_pass) begin
                    lo_reg <= a_reg;
                end else begin
                    hi_reg <= a_reg;
                end
            end
            CMD_BIS_DONE: begin
                alpha_reg <= lo_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        stat.div_busy  = div_busy;
        stat.p_valid   = (c_reg[0] > 32'sd0) && (p_reg > 48'sd0);
        stat.p_pass    = (c_reg[0] > 32'sd0) && (p_reg >= thr_reg);
        stat.cap_need  = cap_need_reg;
        stat.alpha_pos = (alpha_reg != '0);
        stat.invalid   = invalid_reg;

        result.last_cell = last_reg;
        if (invalid_reg || alpha_reg == ONE_FX) begin
            result.delta_density    = d_reg[0];
            result.delta_momentum_x = d_reg[1];
            result.delta_momentum_y = d_reg[2];
            result.delta_energy     = d_reg[3];
            result.scale_factor     = ONE_FX;
            result.limit_status     = invalid_reg ? ST_INVALID : ST_UNCHANGED;
        end else begin
            result.delta_density    = scaled[0];
            result.delta_momentum_x = scaled[1];
            result.delta_momentum_y = scaled[2];
            result.delta_energy     = scaled[3];
            result.scale_factor     = alpha_reg;
            result.limit_status     = ST_SCALED;
        end
    end
endmodule

>>> rtl/core/pul_ctrl.sv
// ----------------------------------------------------------------------------
// pul_ctrl
// Sequencer of the limiter: pressure checks, density cap and bisection.
// ----------------------------------------------------------------------------
module pul_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_free,
    output logic           out_load,
    input  pul_pkg::stat_t stat,
    output pul_pkg::ctrl_t ctrl
);
    import pul_pkg::*;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_P0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        ctrl.cmd   = CMD_NONE;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ctrl.cmd   = CMD_LOAD;
                    phase_next = PH_P0;
                    state_next = S_CAND;
                end
            end
            S_CAND: begin
                ctrl.cmd   = (phase_reg == PH_P0) ? CMD_CAND_STATE : CMD_CAND_TEST;
                state_next = S_SQ;
            end
            S_SQ: begin
                ctrl.cmd   = CMD_SQUARE;
                state_next = S_DIVK;
            end
            S_DIVK: begin
                ctrl.cmd   = CMD_DIV_KIN;
                state_next = S_WAITK;
            end
            S_WAITK: begin
                if (!stat.div_busy) begin
                    state_next = S_INNER;
                end
            end
            S_INNER: begin
                ctrl.cmd   = CMD_INNER;
                state_next = S_PMUL;
            end
            S_PMUL: begin
                ctrl.cmd   = CMD_PMUL;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                case (phase_reg)
                    PH_P0: begin
                        ctrl.cmd   = CMD_SET_P0;
                        state_next = stat.p_valid ? S_CAP_PREP : S_FINAL;
                    end
                    PH_FIRST: begin
                        state_next = stat.p_pass ? S_FINAL : S_BIS_INIT;
                    end
                    default: begin
                        ctrl.cmd  = CMD_BIS_UPDATE;
                        step_next = step_reg + STEP_W'(1);
                        if (step_reg == STEP_W'(BIS_STEPS - 1)) begin
                            state_next = S_BIS_DONE;
                        end else begin
                            state_next = S_BIS_MID;
                        end
                    end
                endcase
            end
            S_CAP_PREP: begin
                ctrl.cmd   = CMD_CAP_PREP;
                state_next = S_CAP_DEC;
            end
            S_CAP_DEC: begin
                if (stat.cap_need) begin
                    ctrl.cmd   = CMD_DIV_CAP;
                    state_next = S_CAP_WAIT;
                end else begin
                    state_next = S_CHECK;
                end
            end
            S_CAP_WAIT: begin
                if (!stat.div_busy) begin
                    ctrl.cmd   = CMD_CAP_SET;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.alpha_pos) begin
                    ctrl.cmd   = CMD_TEST_ALPHA;
                    phase_next = PH_FIRST;
                    state_next = S_CAND;
                end else begin
                    state_next = S_FINAL;
                end
            end
            S_BIS_INIT: begin
                ctrl.cmd   = CMD_BIS_INIT;
                step_next  = '0;
                state_next = S_BIS_MID;
            end
            S_BIS_MID: begin
                ctrl.cmd   = CMD_TEST_MID;
                phase_next = PH_BIS;
                state_next = S_CAND;
            end
            S_BIS_DONE: begin
                ctrl.cmd   = CMD_BIS_DONE;
                state_next = S_FINAL;
            end
            S_FINAL: begin
                if (out_free) begin
                    ctrl.cmd   = CMD_FINAL;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> bench/tb_positivity_update_limiter.sv
// ----------------------------------------------------------------------------
// tb_positivity_update_limiter
// Self-checking bench for the positivity update limiter.
// ----------------------------------------------------------------------------
// Cells go in through a queue-fed driver. A fixed-point predictor computes the
// limited update of each accepted cell, and a monitor compares every result
// word field by field with the oldest prediction. The run steps through
// several gamma and floor settings and three idling regimes.
module tb_positivity_update_limiter;
    import pul_pkg::*;

    typedef struct {
        logic [255:0] data;
        logic         last;
    } cell_word_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [255:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [151:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = REG_HEAT_RATIO;
    logic [17:0]  cfg_wdata = '0;

    cell_word_t   pending_cells[$];
    result_t      expected_limits[$];
    logic [17:0]  gamma_q = HEAT_RATIO_RST;
    logic [15:0]  floor_q = FLOOR_FRAC_RST;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_sender = 1'b0;
    int           errors = 0;
    longint       cycle_count = 0;

    positivity_update_limiter u_dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint floor_q16(longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Returns the pressure, or sets ok to 0 when the density is not positive.
    function automatic longint cell_pressure(longint r, longint mx, longint my,
                                             longint e, output bit ok);
        longint unsigned ax, ay, kin;
        longint inner;
        longint gm1;
        gm1 = longint'(gamma_q) - (64'sd1 <<< FRAC_BITS);
        ok = r > 0;
        if (!ok) return 0;
        ax = mx < 0 ? -mx : mx;
        ay = my < 0 ? -my : my;
        kin = (ax * ax + ay * ay) / (2 * longint'(r));
        inner = e - longint'(kin);
        if (inner < -(64'sd1 <<< 44)) inner = -(64'sd1 <<< 44);
        return floor_q16(gm1 * inner);
    endfunction

    function automatic bit pressure_holds(longint u[4], longint d[4], longint a,
                                          longint thr);
        longint c[4];
        longint p;
        bit ok;
        for (int k = 0; k < 4; k++) c[k] = clip32(u[k] + floor_q16(a * d[k]));
        p = cell_pressure(c[0], c[1], c[2], c[3], ok);
        return ok && p >= thr;
    endfunction

    function automatic result_t limit_cell(cell_word_t w);
        longint u[4], d[4];
        longint ff, p0, thr, alpha, lo, hi, mid, num;
        bit ok;
        result_t r;
        ff = longint'(floor_q);
        alpha = 64'sd1 <<< FRAC_BITS;
        for (int k = 0; k < 4; k++) begin
            u[k] = longint'($signed(w.data[32*k +: 32]));
            d[k] = longint'($signed(w.data[32*(k+4) +: 32]));
        end
        r.delta_density    = d[0][31:0];
        r.delta_momentum_x = d[1][31:0];
        r.delta_momentum_y = d[2][31:0];
        r.delta_energy     = d[3][31:0];
        r.last_cell        = w.last;
        r.limit_status     = ST_UNCHANGED;
        p0 = cell_pressure(u[0], u[1], u[2], u[3], ok);
        if (!ok || p0 <= 0) begin
            r.limit_status = ST_INVALID;
        end else begin
            if (d[0] < 0 && u[0] + d[0] < floor_q16(ff * u[0])) begin
                num = ((64'sd1 <<< FRAC_BITS) - ff) * u[0];
                if (num <= 0) alpha = 0;
                else if (num / (-d[0]) < alpha) alpha = num / (-d[0]);
            end
            thr = floor_q16(ff * p0);
            if (alpha > 0 && !pressure_holds(u, d, alpha, thr)) begin
                lo = 0;
                hi = alpha;
                for (int i = 0; i < BIS_STEPS; i++) begin
                    mid = (lo + hi) >>> 1;
                    if (pressure_holds(u, d, mid, thr)) lo = mid;
                    else hi = mid;
                end
                alpha = lo;
            end
            if (alpha < (64'sd1 <<< FRAC_BITS)) begin
                r.limit_status     = ST_SCALED;
                r.delta_density    = 32'(floor_q16(d[0] * alpha));
                r.delta_momentum_x = 32'(floor_q16(d[1] * alpha));
                r.delta_momentum_y = 32'(floor_q16(d[2] * alpha));
                r.delta_energy     = 32'(floor_q16(d[3] * alpha));
            end
        end
        r.scale_factor = alpha[16:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) expected_limits.push_back(limit_cell('{s_tdata, s_tlast}));
            if (pending_cells.size() > 0 && !hold_sender &&
                    $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= pending_cells[0].data;
                s_tlast  <= pending_cells[0].last;
                s_tvalid <= 1'b1;
                void'(pending_cells.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_limits.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual %h %h %b",
                             $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = expected_limits.pop_front();
                    if (m_tdata[127:0] != {want.delta_energy, want.delta_momentum_y,
                                           want.delta_momentum_x, want.delta_density}) begin
                        errors++;
                        $display("%0t: deltas expected %h actual %h", $time,
                                 {want.delta_energy, want.delta_momentum_y,
                                  want.delta_momentum_x, want.delta_density},
                                 m_tdata[127:0]);
                    end
                    if (m_tdata[144:128] != want.scale_factor) begin
                        errors++;
                        $display("%0t: scale expected %h actual %h", $time,
                                 want.scale_factor, m_tdata[144:128]);
                    end
                    if (m_tuser != want.limit_status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.limit_status, m_tuser);
                    end
                    if (m_tlast != want.last_cell) begin
                        errors++;
                        $display("%0t: last expected %b actual %b", $time,
                                 want.last_cell, m_tlast);
                    end
                end
            end
            m_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > 64'd40000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Queues and the bus are sampled at the falling edge, where they are settled.
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_cells.size() > 0 || s_tvalid || expected_limits.size() > 0)
            @(negedge aclk);
        repeat (1500) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [17:0] value);
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_HEAT_RATIO) gamma_q = value;
        else floor_q = value[15:0];
        @(posedge aclk);
    endtask

    task automatic add_cell(logic [31:0] r, logic [31:0] mx, logic [31:0] my,
                            logic [31:0] e, logic [31:0] dr, logic [31:0] dmx,
                            logic [31:0] dmy, logic [31:0] de, logic last);
        cell_word_t w;
        w.data = {de, dmy, dmx, dr, e, my, mx, r};
        w.last = last;
        pending_cells.push_back(w);
    endtask

    // Mostly physical states with updates that often drive density or pressure low.
    task automatic add_random_cell();
        logic [31:0] r, mx, my, e, dr, dmx, dmy, de;
        case ($urandom_range(9))
            0: begin
                r = $urandom; mx = $urandom; my = $urandom; e = $urandom;
                dr = $urandom; dmx = $urandom; dmy = $urandom; de = $urandom;
            end
            default: begin
                r  = $urandom_range(32'h0300_0000, 32'h0000_1000);
                mx = $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
                my = $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
                e  = $urandom_range(32'h7FFF_FFFF, 32'h0010_0000);
                dr = $signed($urandom_range(32'h0800_0000)) - $signed(r) - 32'sh0200_0000;
                dmx = $signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
                dmy = $signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
                de = $signed($urandom_range(32'h8000_0000)) - $signed(e);
            end
        endcase
        add_cell(r, mx, my, e, dr, dmx, dmy, de, $urandom_range(1));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed cells: extremes, invalid states, density cap and bisection.
        add_cell(32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0, 0, 0, 1'b0);
        add_cell(0, 0, 0, 32'h0002_0000, 1, 1, 1, 1, 1'b1);
        add_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_cell(32'h0001_0000, 32'h0010_0000, 0, 32'h0001_0000, 0, 0, 0, 0, 1'b1);
        add_cell(32'h0001_0000, 0, 0, 32'h0002_0000, 32'hFFFE_0000, 0, 0, 0, 1'b0);
        add_cell(32'h0001_0000, 0, 0, 32'h0002_0000, 32'h8000_0000, 0, 0, 0, 1'b1);
        add_cell(32'h0001_0000, 0, 0, 32'h0002_0000, 0, 0, 0, 32'hFFFC_0000, 1'b0);
        add_cell(32'h0001_0000, 0, 0, 32'h0002_0000, 0, 32'h7FFF_FFFF,
                 32'h8000_0000, 0, 1'b1);
        add_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_cell(32'h0000_0001, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 1, 1, 32'h8000_0000, 1'b1);
        wait_drained();
        hold_sender = 1'b0;

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(REG_HEAT_RATIO, 18'd65536);
                         write_reg(REG_FLOOR_FRAC, 18'd0); end
                1: begin write_reg(REG_HEAT_RATIO, 18'd196608);
                         write_reg(REG_FLOOR_FRAC, 18'd65535); end
                2: begin write_reg(REG_HEAT_RATIO, 18'h3FFFF);
                         write_reg(REG_FLOOR_FRAC, 18'd32768); end
                3: begin write_reg(REG_HEAT_RATIO, 18'd65535);
                         write_reg(REG_FLOOR_FRAC, 18'd6554); end
                default: begin write_reg(REG_HEAT_RATIO, 18'd91750);
                               write_reg(REG_FLOOR_FRAC, 18'd6554); end
            endcase
            send_idle_pct = phase < 2 ? 20 : (phase < 4 ? 67 : 0);
            recv_idle_pct = phase < 2 ? 67 : (phase < 4 ? 20 : 0);
            for (int i = 0; i < 300; i++) begin
                add_random_cell();
                if (i == 150) begin
                    @(negedge aclk);
                    while (pending_cells.size() > 0 || s_tvalid) @(negedge aclk);
                    hold_sender = 1'b1;
                    while (expected_limits.size() > 0) @(negedge aclk);
                    hold_sender = 1'b0;
                end
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
